// ----- hw/rtl/stst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stst_pkg
// Shared types, codes and widths of the timer slot table.
// ----------------------------------------------------------------------------
package stst_pkg;

    localparam int SLOT_COUNT_DEFAULT = 16;

    localparam int DELAY_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;

    // One stored entry: ticks left, handler handle, argument handle
    localparam int ENTRY_W = DELAY_W + 2 * HANDLE_W;

    // Input tdata: delay, handler_id, argument_id (lowest first)
    localparam int S_TDATA_W = ENTRY_W;
    // Output tdata: slot, handler_id_out, argument_id_out, schedule_request,
    // padded to whole bytes
    localparam int M_FIELDS_W = SLOT_W + 2 * HANDLE_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Input mode codes (tuser)
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handler;
        logic [HANDLE_W-1:0] argument;
        logic                sched;
        logic                last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/stst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stst_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module stst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/stst_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stst_engine
// Slot table sequencer: busy bits, entry RAM, add and tick walk.
// ----------------------------------------------------------------------------
module stst_engine #(
    parameter int SLOT_COUNT = stst_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            sched_on,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_mode,
    input  logic [stst_pkg::S_TDATA_W-1:0]  in_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output stst_pkg::result_t               res
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    stst_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SLOT_COUNT-1:0] busy_reg, busy_next;

    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [stst_pkg::ENTRY_W-1:0]  wr_data;
    logic [IDX_W-1:0]              rd_addr;
    logic [stst_pkg::ENTRY_W-1:0]  rd_data;

    logic [stst_pkg::DELAY_W-1:0]  rd_ticks;
    logic [stst_pkg::HANDLE_W-1:0] rd_handler;
    logic [stst_pkg::HANDLE_W-1:0] rd_argument;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             accept;
    logic             cur_busy;
    logic             expire;
    logic             advance;

    assign {rd_argument, rd_handler, rd_ticks} = rd_data;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign accept   = in_valid && in_ready;
    assign cur_busy = busy_reg[idx_reg];
    // Zero and one both expire
    assign expire   = (state_reg == stst_pkg::ST_WALK) && cur_busy
                      && (rd_ticks[stst_pkg::DELAY_W-1:1] == '0);
    assign advance  = !expire || res_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stst_pkg::ST_IDLE: begin
                if (accept && in_mode == stst_pkg::MODE_TICK) begin
                    state_next = stst_pkg::ST_WALK;
                end
            end
            stst_pkg::ST_WALK: begin
                if (advance && idx_reg == IDX_LAST) begin
                    state_next = stst_pkg::ST_DONE;
                end
            end
            stst_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = stst_pkg::ST_IDLE;
                end
            end
            default: state_next = stst_pkg::ST_IDLE;
        endcase
    end

    // Outputs and RAM control
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = {rd_argument, rd_handler, rd_ticks - stst_pkg::DELAY_W'(1)};
        rd_addr   = '0;
        unique case (state_reg)
            stst_pkg::ST_IDLE: begin
                in_ready = res_ready;
                if (in_valid && in_mode == stst_pkg::MODE_ADD) begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    if (free_found) begin
                        res.kind = stst_pkg::KIND_ACCEPTED;
                        res.slot = stst_pkg::SLOT_W'(free_idx);
                    end else begin
                        res.kind = stst_pkg::KIND_DROPPED;
                    end
                end
                wr_en   = accept && in_mode == stst_pkg::MODE_ADD && free_found;
                wr_addr = free_idx;
                wr_data = in_data;
            end
            stst_pkg::ST_WALK: begin
                res_valid    = expire;
                res.kind     = stst_pkg::KIND_EXPIRED;
                res.slot     = stst_pkg::SLOT_W'(idx_reg);
                res.handler  = rd_handler;
                res.argument = rd_argument;
                // Write back the decremented count of a surviving slot
                wr_en   = advance && cur_busy && !expire;
                rd_addr = advance ? idx_reg + IDX_W'(1) : idx_reg;
            end
            stst_pkg::ST_DONE: begin
                res_valid = 1'b1;
                res.kind  = stst_pkg::KIND_TICK_DONE;
                res.sched = sched_on;
                res.last  = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Busy bits and walk index
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (state_reg == stst_pkg::ST_IDLE) begin
            idx_next = '0;
            if (accept && in_mode == stst_pkg::MODE_ADD && free_found) begin
                busy_next[free_idx] = 1'b1;
            end
        end else if (state_reg == stst_pkg::ST_WALK && advance) begin
            idx_next = idx_reg + IDX_W'(1);
            if (expire) begin
                busy_next[idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stst_pkg::ST_IDLE;
            idx_reg   <= '0;
            busy_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
        end
    end

    stst_ram #(
        .WIDTH (stst_pkg::ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- hw/rtl/stst_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stst_out_buf
// Two-entry result queue between the sequencer and the master port.
// ----------------------------------------------------------------------------
module stst_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  stst_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output stst_pkg::result_t out_res
);

    stst_pkg::result_t entry_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/software_timer_slot_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_slot_table
// Fixed table of timer slots with add and tick-walk handling.
// ----------------------------------------------------------------------------
// Results: a result reaches m_tvalid in the cycle after it enters the
//   result queue; an add answers in the cycle after its beat is accepted.
// Throughput: adds go back to back while the result queue has room; a tick
//   walks the RAM one entry per cycle (read-modify-write), then sends the
//   tick-done beat, holding while the result queue cannot take an expiry.
// Reset: synchronous, active low; all slots free, scheduling flag cleared,
//   result queue empty. No clearing pass is needed.
//
// The entry RAM holds ticks left, handler and argument per slot. Busy bits
// live in flip-flops so that an add finds the lowest free slot at once.
// A tick walks the RAM in ascending order: the read of slot i+1 is issued in
// the same cycle slot i is written back, so no entry is read while its own
// write is pending. An expiry that the queue cannot take holds the walk at
// its slot, re-reading the same unchanged entry.
module software_timer_slot_table #(
    parameter int SLOT_COUNT = stst_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Configuration write: scheduling_on
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,

    // Input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] delay, [47:32] handler_id, [63:48] argument_id
    input  logic [stst_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                           s_tuser,

    // Result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] slot, [19:4] handler_id_out, [35:20] argument_id_out,
    // [36] schedule_request, [39:37] zero
    output logic [stst_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [stst_pkg::KIND_W-1:0]    m_tuser,
    output logic                           m_tlast
);

    logic sched_on_reg, sched_on_next;

    logic              eng_valid;
    logic              eng_ready;
    stst_pkg::result_t eng_res;
    stst_pkg::result_t out_res;

    // Configuration is always taken; keep only the flag bit
    assign cfg_ready = 1'b1;

    always_comb begin
        sched_on_next = sched_on_reg;
        if (cfg_valid && cfg_ready) begin
            sched_on_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_on_reg <= 1'b0;
        end else begin
            sched_on_reg <= sched_on_next;
        end
    end

    // Sequencer: busy bits, entry RAM, add and tick walk
    stst_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sched_on  (sched_on_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_data   (s_tdata),
        .res_valid (eng_valid),
        .res_ready (eng_ready),
        .res       (eng_res)
    );

    // Result queue decouples the walk from master-side stalls
    stst_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (eng_valid),
        .in_ready  (eng_ready),
        .in_res    (eng_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result beat
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;
    assign m_tdata = {
        (stst_pkg::M_TDATA_W - stst_pkg::M_FIELDS_W)'(0),
        out_res.sched,
        out_res.argument,
        out_res.handler,
        out_res.slot
    };

endmodule
